// ----- hdl/adi_pkg.sv -----
`default_nettype none
package adi_pkg;

    localparam int DEBOUNCE_TOP = 3;
    localparam int TIME_BITS    = 16;
    localparam int DEB_ON       = 2;
    localparam int DEB_W        = $clog2(DEBOUNCE_TOP + 1);
    localparam int INT_W        = 16;
    localparam int CMP_W        = (TIME_BITS > INT_W) ? TIME_BITS : INT_W;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        ACT_SAMPLE = 3'd0,
        ACT_TICK   = 3'd1,
        ACT_ALARM  = 3'd2,
        ACT_LED    = 3'd3,
        ACT_BUZZER = 3'd4,
        ACT_SYSTEM = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        LED_NORMAL = 2'd0,
        LED_FAST   = 2'd1,
        LED_HOLD   = 2'd2
    } t_ind_mode;

    typedef enum logic [1:0] {
        REG_TEMP_LIMIT  = 2'd0,
        REG_HUMID_LIMIT = 2'd1,
        REG_SLOW_IVL    = 2'd2,
        REG_FAST_IVL    = 2'd3
    } t_reg_idx;

    localparam logic signed [15:0] TEMP_LIMIT_RST  = 16'sd3000;
    localparam logic [13:0]        HUMID_LIMIT_RST = 14'd8000;
    localparam logic [15:0]        SLOW_IVL_RST    = 16'd1000;
    localparam logic [15:0]        FAST_IVL_RST    = 16'd200;

    typedef struct packed {
        logic signed [15:0] temp_limit;
        logic [13:0]        humid_limit;
        logic [15:0]        slow_interval_ms;
        logic [15:0]        fast_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         action;
        logic               sample_valid;
        logic signed [15:0] temperature;
        logic [13:0]        humidity;
        logic               flag_value;
        logic [1:0]         ind_mode_value;
        logic [15:0]        buzzer_ms;
    } t_in_word;

    typedef struct packed {
        logic alarm_request;
        logic led_on;
        logic buzzer_on;
        logic fast_rate;
    } t_result;

    typedef struct packed {
        logic                 alarm_flag;
        logic [DEB_W-1:0]     deb_count;
        logic                 system_on;
        t_ind_mode            mode;
        logic                 led_level;
        logic [TIME_BITS-1:0] since_toggle;
        logic                 timed_buzz;
        logic [TIME_BITS-1:0] buzz_remaining;
        logic                 buzzer_level;
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/adi_if.sv -----
`default_nettype none
interface adi_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic               sample_valid;
    logic signed [15:0] temperature;
    logic [13:0]        humidity;
    logic               flag_value;
    logic [1:0]         ind_mode_value;
    logic [15:0]        buzzer_ms;

    modport source (
        output valid, action, sample_valid, temperature, humidity,
               flag_value, ind_mode_value, buzzer_ms,
        input  ready
    );
    modport sink (
        input  valid, action, sample_valid, temperature, humidity,
               flag_value, ind_mode_value, buzzer_ms,
        output ready
    );
endinterface

interface adi_out_if;
    logic valid;
    logic ready;
    logic alarm_request;
    logic led_on;
    logic buzzer_on;
    logic fast_rate;

    modport source (
        output valid, alarm_request, led_on, buzzer_on, fast_rate,
        input  ready
    );
    modport sink (
        input  valid, alarm_request, led_on, buzzer_on, fast_rate,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/alarm_debounce_indicator.sv -----
`default_nettype none
// Path: a taken word is held in the input register, then its result is loaded into the
// result register once that register is empty or the sink takes the word it holds.
// Throughput: one word per clock while the sink keeps ready high; the combinational
// state update in adi_core sits between the input register and the result register.
// Reset (synchronous, active low): limits and intervals return to defaults,
// all state clears except the toggle timer, which saturates.
module alarm_debounce_indicator
    import adi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    adi_in_if.sink      i_in,
    adi_out_if.source   o_out,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [15:0]  i_cfg_data
);

    t_cfg     r_cfg;
    t_state   r_st;
    t_state   n_st;
    t_in_word r_in;
    logic     r_in_valid;
    t_result  r_res;
    t_result  n_res;
    logic     r_out_valid;
    logic     w_adv;
    logic     w_take;

    assign w_adv  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit       <= TEMP_LIMIT_RST;
            r_cfg.humid_limit      <= HUMID_LIMIT_RST;
            r_cfg.slow_interval_ms <= SLOW_IVL_RST;
            r_cfg.fast_interval_ms <= FAST_IVL_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TEMP_LIMIT:  r_cfg.temp_limit       <= $signed(i_cfg_data);
                REG_HUMID_LIMIT: r_cfg.humid_limit      <= i_cfg_data[13:0];
                REG_SLOW_IVL:    r_cfg.slow_interval_ms <= i_cfg_data;
                REG_FAST_IVL:    r_cfg.fast_interval_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action         <= i_in.action;
            r_in.sample_valid   <= i_in.sample_valid;
            r_in.temperature    <= i_in.temperature;
            r_in.humidity       <= i_in.humidity;
            r_in.flag_value     <= i_in.flag_value;
            r_in.ind_mode_value <= i_in.ind_mode_value;
            r_in.buzzer_ms      <= i_in.buzzer_ms;
        end
    end

    adi_core u_core (
        .i_state (r_st),
        .i_cfg   (r_cfg),
        .i_word  (r_in),
        .o_state (n_st),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.alarm_flag     <= 1'b0;
            r_st.deb_count      <= '0;
            r_st.system_on      <= 1'b0;
            r_st.mode           <= LED_NORMAL;
            r_st.led_level      <= 1'b0;
            r_st.since_toggle   <= TIME_MAX;
            r_st.timed_buzz     <= 1'b0;
            r_st.buzz_remaining <= '0;
            r_st.buzzer_level   <= 1'b0;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    // Result register: hold until the sink takes the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.alarm_request = r_res.alarm_request;
    assign o_out.led_on        = r_res.led_on;
    assign o_out.buzzer_on     = r_res.buzzer_on;
    assign o_out.fast_rate     = r_res.fast_rate;

`ifndef SYNTH
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a blocked result");

    a_deb_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_st.deb_count) <= 32'(DEBOUNCE_TOP))
        else $error("debounce count above top");

    a_adv_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed word produced no result");

    a_sleep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.action == ACT_SYSTEM && !r_in.flag_value)
        |=> (!r_st.alarm_flag && !r_st.led_level && !r_st.buzzer_level && !r_st.system_on))
        else $error("sleep left indicator state set");

    a_hold_lights_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.action == ACT_TICK && r_st.system_on && r_st.mode == LED_HOLD)
        |=> r_st.led_level)
        else $error("hold mode tick left LED off");
`endif

endmodule
`default_nettype wire

// ----- hdl/adi_core.sv -----
`default_nettype none
module adi_core
    import adi_pkg::*;
(
    input  t_state   i_state,
    input  t_cfg     i_cfg,
    input  t_in_word i_word,
    output t_state   o_state,
    output t_result  o_res
);

    always_comb begin
        t_state               st;
        logic                 over;
        logic                 sample;
        logic                 request;
        logic                 fast;
        logic [INT_W-1:0]     interval;
        logic [CMP_W-1:0]     ms_ext;
        logic [31:0]          cnt_ext;

        st       = i_state;
        sample   = 1'b0;
        request  = 1'b0;
        over     = 1'b0;
        fast     = 1'b0;
        interval = '0;
        ms_ext   = CMP_W'(i_word.buzzer_ms);
        cnt_ext  = '0;

        unique case (t_action'(i_word.action))
            ACT_SAMPLE: begin
                over = i_word.sample_valid &&
                       (($signed(i_word.temperature) > $signed(i_cfg.temp_limit)) ||
                        (i_word.humidity > i_cfg.humid_limit));
                if (over) begin
                    if (32'(st.deb_count) < 32'(DEBOUNCE_TOP)) begin
                        st.deb_count = st.deb_count + DEB_W'(1);
                    end
                end else if (st.deb_count != '0) begin
                    st.deb_count = st.deb_count - DEB_W'(1);
                end
                cnt_ext = 32'(st.deb_count);
                if (!st.alarm_flag && cnt_ext >= 32'(DEB_ON)) begin
                    request = 1'b1;
                end else if (st.alarm_flag && st.deb_count == '0) begin
                    request = 1'b0;
                end else begin
                    request = st.alarm_flag;
                end
                sample = 1'b1;
            end
            ACT_TICK: begin
                // Time counters run even while asleep
                if (st.since_toggle != TIME_MAX) begin
                    st.since_toggle = st.since_toggle + TIME_BITS'(1);
                end
                if (st.buzz_remaining != '0) begin
                    st.buzz_remaining = st.buzz_remaining - TIME_BITS'(1);
                end
                if (st.system_on) begin
                    if (st.timed_buzz && st.buzz_remaining == '0) begin
                        st.timed_buzz   = 1'b0;
                        st.buzzer_level = 1'b0;
                    end
                    if (st.mode == LED_HOLD) begin
                        st.led_level = 1'b1;
                    end else begin
                        fast     = st.alarm_flag || st.mode == LED_FAST;
                        interval = fast ? i_cfg.fast_interval_ms : i_cfg.slow_interval_ms;
                        if (CMP_W'(st.since_toggle) >= CMP_W'(interval)) begin
                            st.since_toggle = '0;
                            st.led_level    = ~st.led_level;
                            st.buzzer_level = st.timed_buzz ||
                                (st.alarm_flag && st.mode == LED_NORMAL && st.led_level);
                        end
                    end
                end
            end
            ACT_ALARM: begin
                st.alarm_flag = i_word.flag_value;
                if (!i_word.flag_value) begin
                    st.deb_count = '0;
                end
            end
            ACT_LED: begin
                // Mode code three is ignored
                if (i_word.ind_mode_value != 2'd3) begin
                    st.mode         = t_ind_mode'(i_word.ind_mode_value);
                    st.since_toggle = TIME_MAX;
                    if (st.mode == LED_HOLD) begin
                        st.timed_buzz   = 1'b0;
                        st.led_level    = 1'b1;
                        st.buzzer_level = 1'b0;
                    end else if (st.mode == LED_NORMAL) begin
                        st.timed_buzz   = 1'b0;
                        st.buzzer_level = 1'b0;
                    end
                end
            end
            ACT_BUZZER: begin
                if (i_word.buzzer_ms == '0) begin
                    st.timed_buzz   = 1'b0;
                    st.buzzer_level = 1'b0;
                end else begin
                    st.timed_buzz     = 1'b1;
                    st.buzz_remaining = (ms_ext > CMP_W'(TIME_MAX)) ? TIME_MAX
                                                                    : TIME_BITS'(ms_ext);
                    st.buzzer_level   = 1'b1;
                end
            end
            ACT_SYSTEM: begin
                st.system_on = i_word.flag_value;
                if (!i_word.flag_value) begin
                    st.alarm_flag   = 1'b0;
                    st.deb_count    = '0;
                    st.mode         = LED_NORMAL;
                    st.led_level    = 1'b0;
                    st.timed_buzz   = 1'b0;
                    st.buzzer_level = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (!sample) begin
            request = st.alarm_flag;
        end

        o_state             = st;
        o_res.alarm_request = request;
        o_res.led_on        = st.led_level;
        o_res.buzzer_on     = st.buzzer_level;
        o_res.fast_rate     = st.alarm_flag || st.mode == LED_FAST;
    end

endmodule
`default_nettype wire
